@@ rtl/core/sme_pkg.sv @@
// Shared types and opcode/fault codes for the stack machine execute unit.
`timescale 1ns / 1ps
package sme_pkg;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_PUSHR = 5'd1, OP_POPR = 5'd2, OP_ADD = 5'd3,
    OP_SUB = 5'd4, OP_MUL = 5'd5, OP_DIV = 5'd6, OP_SQRT = 5'd7,
    OP_SIN = 5'd8, OP_COS = 5'd9, OP_OUT = 5'd10, OP_JMP = 5'd11,
    OP_JB = 5'd12, OP_JBE = 5'd13, OP_JA = 5'd14, OP_JAE = 5'd15,
    OP_JE = 5'd16, OP_JNE = 5'd17, OP_HLT = 5'd18
  } opcode_t;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_OPCODE = 3'd1, FLT_UNDER = 3'd2, FLT_OVER = 3'd3,
    FLT_DIV0 = 3'd4, FLT_SQRT = 3'd5, FLT_REG = 3'd6
  } fault_t;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [31:0] operand;
  } sme_in_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic [2:0]         fault;
  } sme_out_t;

endpackage

@@ rtl/core/stack_machine_execute_unit.sv @@
// Execute unit of a 32-bit stack machine with a memory-based data stack.
//
//   Channel | Signals                      | Payload
//   in      | in_valid, in_ready, in_data  | sme_in_t  (opcode, operand)
//   out     | out_valid, out_ready, out_data | sme_out_t (next_ip ... fault)
//
// One instruction at a time. Most pass through these steps between acceptances:
// accept, read the top of stack, read the second entry, execute and write back,
// then load the output register. div and sqrt add an iterate state in a
// shared one-bit-per-cycle unit.
// Reset clears depth, IP, halt and the register file; stack memory is not
// cleared. The result waits in an output register; a new item is accepted
// once that register is free or being taken.
`timescale 1ns / 1ps
module stack_machine_execute_unit
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int REG_COUNT   = 8,
  parameter int IP_WIDTH    = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sme_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sme_out_t out_data
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_DONE
  } state_t;

  state_t state;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic [SAW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [SAW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic [31:0] regs [REG_COUNT];
  logic [SDW-1:0] depth;
  logic [IP_WIDTH-1:0] ip;
  logic halt;

  logic [4:0] op;
  logic [31:0] word;
  logic [31:0] a, b;
  logic [5:0] cnt;
  // Shared iterative unit: restoring divide, or digit-by-digit square root.
  logic [31:0] q, rem, x;
  logic [31:0] sq_rem;
  logic [31:0] sq_root;
  logic neg_res;

  // Stack memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  // The second entry is on the read port during the execute cycle.
  assign b = rd_data;

  logic [IP_WIDTH-1:0] ip_p1, ip_p2, ip_tgt;
  assign ip_p1 = ip + IP_WIDTH'(1);
  assign ip_p2 = ip + IP_WIDTH'(2);
  assign ip_tgt = word[IP_WIDTH-1:0];

  logic reg_bad;
  assign reg_bad = (word >= 32'(REG_COUNT));

  logic [1:0] need;
  logic grows;
  always_comb begin
    need = 2'd0;
    grows = 1'b0;
    case (op) inside
      OP_PUSH, OP_PUSHR: grows = 1'b1;
      OP_POPR, OP_SQRT, OP_SIN, OP_COS, OP_OUT: need = 2'd1;
      [OP_ADD:OP_DIV], [OP_JB:OP_JNE]: need = 2'd2;
      default: need = 2'd0;
    endcase
  end

  logic [2:0] pre_fault;
  always_comb begin
    if (op > OP_HLT) pre_fault = FLT_OPCODE;
    else if ((op == OP_PUSHR || op == OP_POPR) && reg_bad) pre_fault = FLT_REG;
    else if (depth < SDW'(need)) pre_fault = FLT_UNDER;
    else if (grows && depth >= SDW'(STACK_DEPTH)) pre_fault = FLT_OVER;
    else pre_fault = FLT_NONE;
  end

  logic cmp;
  always_comb begin
    case (op)
      OP_JB:   cmp = $signed(a) < $signed(b);
      OP_JBE:  cmp = $signed(a) <= $signed(b);
      OP_JA:   cmp = $signed(a) > $signed(b);
      OP_JAE:  cmp = $signed(a) >= $signed(b);
      OP_JE:   cmp = a == b;
      default: cmp = a != b;
    endcase
  end

  logic [32:0] div_trial;
  logic [31:0] div_shift;
  logic [33:0] sq_trial;
  logic [33:0] sq_shift;
  always_comb begin
    div_shift = {rem[30:0], x[31]};
    div_trial = {1'b0, div_shift} - {1'b0, (a[31] ? -a : a)};
    sq_shift = {sq_rem, x[31:30]};
    sq_trial = sq_shift - {sq_root, 2'b01};
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    rd_en <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      ip <= '0;
      halt <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= in_data.opcode;
            word <= in_data.operand;
            rd_addr <= SAW'(depth - SDW'(1));
            rd_en <= 1'b1;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          rd_addr <= SAW'(depth - SDW'(2));
          rd_en <= 1'b1;
          state <= S_RD2;
        end
        S_RD2: begin
          a <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          out_data.out_valid <= 1'b0;
          out_data.out_value <= '0;
          out_data.fault <= FLT_NONE;
          state <= S_DONE;
          if (halt) begin
            out_data.halted <= 1'b1;
          end else if (pre_fault != FLT_NONE) begin
            halt <= 1'b1;
            out_data.halted <= 1'b1;
            out_data.fault <= pre_fault;
          end else if (op == OP_DIV && a == '0) begin
            halt <= 1'b1;
            out_data.halted <= 1'b1;
            out_data.fault <= FLT_DIV0;
          end else if (op == OP_SQRT && a[31]) begin
            halt <= 1'b1;
            out_data.halted <= 1'b1;
            out_data.fault <= FLT_SQRT;
          end else begin
            out_data.halted <= 1'b0;
            case (op) inside
              OP_HLT: begin
                halt <= 1'b1;
                out_data.halted <= 1'b1;
              end
              OP_PUSH, OP_PUSHR: begin
                wr_en <= 1'b1;
                wr_addr <= SAW'(depth);
                wr_data <= (op == OP_PUSH) ? word : regs[word[RAW-1:0]];
                depth <= depth + SDW'(1);
                ip <= ip_p2;
              end
              OP_POPR: begin
                regs[word[RAW-1:0]] <= a;
                depth <= depth - SDW'(1);
                ip <= ip_p2;
              end
              OP_ADD, OP_SUB, OP_MUL: begin
                wr_en <= 1'b1;
                wr_addr <= SAW'(depth - SDW'(2));
                wr_data <= (op == OP_ADD) ? rd_data + a :
                           (op == OP_SUB) ? rd_data - a : rd_data * a;
                depth <= depth - SDW'(1);
                ip <= ip_p1;
              end
              OP_DIV: begin
                x <= rd_data[31] ? -rd_data : rd_data;
                neg_res <= rd_data[31] ^ a[31];
                rem <= '0;
                q <= '0;
                cnt <= '0;
                state <= S_ITER;
              end
              OP_SQRT: begin
                x <= a;
                sq_rem <= '0;
                sq_root <= '0;
                cnt <= 6'd16;
                state <= S_ITER;
              end
              OP_SIN, OP_COS: begin
                wr_en <= 1'b1;
                wr_addr <= SAW'(depth - SDW'(1));
                wr_data <= (op == OP_COS && a == '0) ? 32'd1 : 32'd0;
                ip <= ip_p1;
              end
              OP_OUT: begin
                out_data.out_valid <= 1'b1;
                out_data.out_value <= a;
                depth <= depth - SDW'(1);
                ip <= ip_p1;
              end
              OP_JMP: ip <= ip_tgt;
              default: begin
                depth <= depth - SDW'(2);
                ip <= cmp ? ip_tgt : ip_p2;
              end
            endcase
          end
        end
        S_ITER: begin
          out_data.halted <= 1'b0;
          if (op == OP_DIV) begin
            x <= {x[30:0], 1'b0};
            if (!div_trial[32]) begin
              rem <= div_trial[31:0];
              q <= {q[30:0], 1'b1};
            end else begin
              rem <= div_shift;
              q <= {q[30:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd32) begin
              wr_en <= 1'b1;
              wr_addr <= SAW'(depth - SDW'(2));
              wr_data <= neg_res ? -q : q;
              depth <= depth - SDW'(1);
              ip <= ip_p1;
              state <= S_DONE;
            end
          end else begin
            if (cnt == 6'd0) begin
              wr_en <= 1'b1;
              wr_addr <= SAW'(depth - SDW'(1));
              wr_data <= sq_root;
              ip <= ip_p1;
              state <= S_DONE;
            end else begin
              x <= {x[29:0], 2'b00};
              if (!sq_trial[33]) begin
                sq_rem <= sq_trial[31:0];
                sq_root <= {sq_root[30:0], 1'b1};
              end else begin
                sq_rem <= sq_shift[31:0];
                sq_root <= {sq_root[30:0], 1'b0};
              end
              cnt <= cnt - 6'd1;
            end
          end
        end
        S_DONE: begin
          out_data.next_ip <= 16'(ip);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // In the divide loop, steps 0..31 build the quotient and step 32 commits
  // it.

  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("input accepted while busy");
  assert property (@(posedge clk) disable iff (rst) depth <= SDW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fault != FLT_NONE) |-> out_data.halted)
    else $error("fault reported without halt");
  assert property (@(posedge clk) disable iff (rst) $rose(halt) |=> $stable(ip))
    else $error("IP moved after halt");

endmodule

@@ test/stack_machine_execute_unit_checker.sv @@
// Checker that predicts and compares every result of the execute unit.
`timescale 1ns / 1ps
module stack_machine_execute_unit_checker
  import sme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sme_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  sme_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int STACK_SIZE = 64;
  localparam int NUM_REGS = 8;

  logic [31:0] stack_mem [STACK_SIZE];
  int          depth;
  logic [31:0] regs [NUM_REGS];
  logic [15:0] ip;
  logic        stopped;
  sme_out_t    expected_results [$];

  function automatic logic [31:0] isqrt(logic [31:0] x);
    logic [31:0] res;
    logic [31:0] b;
    res = 0;
    b = 32'h4000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Runs one instruction on the shadow machine and returns its result.
  function automatic sme_out_t execute(sme_in_t item);
    sme_out_t r;
    fault_t flt;
    int need;
    logic grows, uses_reg, taken;
    logic [4:0] op;
    logic [31:0] w, a, b, v;
    op = item.opcode;
    w = item.operand;
    r = '0;
    flt = FLT_NONE;
    if (!stopped) begin
      need = 0;
      grows = (op == OP_PUSH || op == OP_PUSHR);
      uses_reg = (op == OP_PUSHR || op == OP_POPR);
      if (op == OP_POPR || (op >= OP_SQRT && op <= OP_OUT)) need = 1;
      else if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_JB && op <= OP_JNE)) need = 2;
      if (op > OP_HLT) flt = FLT_OPCODE;
      else if (uses_reg && w >= NUM_REGS) flt = FLT_REG;
      else if (depth < need) flt = FLT_UNDER;
      else if (grows && depth >= STACK_SIZE) flt = FLT_OVER;
      else if (op == OP_DIV && stack_mem[depth-1] == 0) flt = FLT_DIV0;
      else if (op == OP_SQRT && stack_mem[depth-1][31]) flt = FLT_SQRT;
      if (flt != FLT_NONE || op == OP_HLT) begin
        stopped = 1;
      end else if (grows) begin
        stack_mem[depth] = (op == OP_PUSH) ? w : regs[w[2:0]];
        depth++;
        ip = ip + 2;
      end else if (op == OP_POPR) begin
        depth--;
        regs[w[2:0]] = stack_mem[depth];
        ip = ip + 2;
      end else if (op >= OP_ADD && op <= OP_DIV) begin
        depth--;
        a = stack_mem[depth];
        b = stack_mem[depth-1];
        case (op)
          OP_ADD: v = b + a;
          OP_SUB: v = b - a;
          OP_MUL: v = b * a;
          default: begin
            if (a == 32'hFFFF_FFFF) v = -b;
            else v = $signed(b) / $signed(a);
          end
        endcase
        stack_mem[depth-1] = v;
        ip = ip + 1;
      end else if (op >= OP_SQRT && op <= OP_COS) begin
        a = stack_mem[depth-1];
        if (op == OP_SQRT) v = isqrt(a);
        else if (op == OP_SIN) v = 0;
        else v = (a == 0);
        stack_mem[depth-1] = v;
        ip = ip + 1;
      end else if (op == OP_OUT) begin
        depth--;
        r.out_valid = 1;
        r.out_value = stack_mem[depth];
        ip = ip + 1;
      end else if (op == OP_JMP) begin
        ip = w[15:0];
      end else begin
        a = stack_mem[depth-1];
        b = stack_mem[depth-2];
        depth -= 2;
        case (op)
          OP_JB:   taken = $signed(a) < $signed(b);
          OP_JBE:  taken = $signed(a) <= $signed(b);
          OP_JA:   taken = $signed(a) > $signed(b);
          OP_JAE:  taken = $signed(a) >= $signed(b);
          OP_JE:   taken = a == b;
          default: taken = a != b;
        endcase
        ip = taken ? w[15:0] : ip + 2;
      end
    end
    r.next_ip = ip;
    r.halted = stopped;
    r.fault = flt;
    return r;
  endfunction

  always @(posedge clk) begin
    sme_out_t exp_r;
    if (rst) begin
      depth = 0;
      ip = 0;
      stopped = 0;
      fail_count = 0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count = fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(execute(in_data));
      pending = expected_results.size();
    end
  end

endmodule

@@ test/stack_machine_execute_unit_test.sv @@
// Testbench top: stimulus, reset and verdict for the stack machine execute unit.
`timescale 1ns / 1ps
module stack_machine_execute_unit_test
  import sme_pkg::*;
();

  logic     clk = 0;
  logic     rst = 1;
  logic     in_valid = 0;
  logic     in_ready;
  sme_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  sme_out_t out_data;
  int       fail_count;
  int       pending;
  logic     calm = 0;

  always #2 clk = ~clk;

  stack_machine_execute_unit dut (.*);

  stack_machine_execute_unit_checker checker_i (.*);

  // Receiver stalls at random except in the calm stretch.
  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

  task automatic send(logic [4:0] op, logic [31:0] w);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, operand: w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // The machine halts for good, so each program needs a fresh reset state;
  // since reset is applied only once, the whole run is one long program that
  // keeps the machine alive and ends with the fault and halt cases.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 0;
      4: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // Keeps a shadow of the depth so the random program never faults.
  int sdepth;
  logic [31:0] top;
  task automatic safe_item();
    int k;
    logic [4:0] op;
    k = $urandom_range(99);
    if (sdepth < 2 || (k < 35 && sdepth < 60)) begin
      op = $urandom_range(1) ? OP_PUSH : OP_PUSHR;
      if (op == OP_PUSH) begin
        top = rand_word();
        send(OP_PUSH, top);
      end else begin
        top = 32'hx;
        send(OP_PUSHR, $urandom_range(7));
      end
      sdepth++;
    end else if (k < 45) begin
      send(OP_POPR, $urandom_range(7));
      sdepth--;
      top = 32'hx;
    end else if (k < 60) begin
      op = 5'(OP_ADD + $urandom_range(2));
      send(op, $urandom);
      sdepth--;
      top = 32'hx;
    end else if (k < 70) begin
      // Divide and sqrt only on a known safe top of stack.
      top = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3) : $urandom;
      if (top == 0) top = 1;
      send(OP_PUSH, top);
      if ($urandom_range(1) || sdepth > 61) begin
        send(OP_DIV, $urandom);
      end else begin
        send(OP_PUSH, $urandom_range(1) ? $urandom >> 1 : 32'h7FFF_FFFF);
        send(OP_SQRT, $urandom);
        send(OP_ADD, $urandom);
        sdepth++;
      end
      top = 32'hx;
    end else if (k < 78) begin
      send(5'(OP_SIN + $urandom_range(1)), $urandom);
    end else if (k < 86) begin
      send(OP_OUT, $urandom);
      sdepth--;
    end else if (k < 90) begin
      send(OP_JMP, $urandom);
    end else begin
      send(5'(OP_JB + $urandom_range(5)), $urandom);
      sdepth -= 2;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sdepth = 0;
    // Directed: extremes, most operations, divide overflow, a tie on jae.
    send(OP_PUSH, 32'h8000_0000);
    send(OP_PUSH, 32'hFFFF_FFFF);
    send(OP_DIV, 0);
    send(OP_OUT, 0);
    send(OP_PUSH, 32'h7FFF_FFFF);
    send(OP_SQRT, 0);
    send(OP_COS, 0);
    send(OP_PUSH, 0);
    send(OP_COS, 0);
    send(OP_SIN, 0);
    send(OP_POPR, 7);
    send(OP_PUSHR, 7);
    send(OP_MUL, 0);
    send(OP_PUSHR, 0);
    send(OP_PUSH, 5);
    send(OP_PUSH, 5);
    send(OP_JAE, 32'hFFFF_FFF0);
    send(OP_SUB, 0);
    send(OP_JMP, 32'h0001_FFFF);
    send(OP_OUT, 0);
    sdepth = 0;
    for (int i = 0; i < 1500; i++) begin
      if (i == 300) calm = 1;
      if (i == 700) calm = 0;
      safe_item();
    end
    // Drain the stack through out, then overflow it.
    while (sdepth > 0) begin
      send(OP_OUT, 0);
      sdepth--;
    end
    for (int i = 0; i < 65; i++) send(OP_PUSH, i);
    // Ignored after halt, including an unknown opcode.
    send(5'd31, 0);
    send(OP_HLT, 0);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[stack_machine_execute_unit] OK");
    else $display("[stack_machine_execute_unit] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[stack_machine_execute_unit] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sme_pkg.sv
rtl/core/stack_machine_execute_unit.sv
test/stack_machine_execute_unit_checker.sv
test/stack_machine_execute_unit_test.sv
